>>> design/alkc_pkg.sv
// package: sizes, key type and widths for the address keyed lru cache
`timescale 1ns / 1ps

package alkc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int SLOT_W        = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int COUNT_W       = $clog2(CACHE_ENTRIES + 1);
    localparam int SLOT_IDX_W    = 4;

    localparam int FAMILY_W = 16;
    localparam int PORT_W   = 16;
    localparam int FLOW_W   = 32;
    localparam int ADDR_W   = 64;
    localparam int SCOPE_W  = 32;

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        logic [FAMILY_W-1:0] family;
        logic [PORT_W-1:0]   port;
        logic [FLOW_W-1:0]   flow;
        logic [ADDR_W-1:0]   addr_upper;
        logic [ADDR_W-1:0]   addr_lower;
        logic [SCOPE_W-1:0]  scope;
    } t_key;

endpackage

>>> design/address_keyed_lru_cache.sv
// top level: fully associative lru cache keyed by an ipv6 socket address
`timescale 1ns / 1ps

// Each lookup transfer lands in an input register; when the output register is free its key
// is compared against all sixteen stored keys at once, the recency ranks are updated and the
// result (slot, hit, evict) is written into the output register, so one lookup completes per
// cycle while the output is not stalled. The key match and rank update are done in parallel
// in the same cycle, so a lookup always sees the state left by the one before it. A result
// waiting under stall holds back processing but the input register still takes one more
// transfer. Reset clears the valid bits and ranks at once; no clearing pass is needed and
// lookups are taken from the first cycle after reset.
module address_keyed_lru_cache
    import alkc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [FAMILY_W-1:0]   i_addr_family,
    input  logic [PORT_W-1:0]     i_port_number,
    input  logic [FLOW_W-1:0]     i_flow_label,
    input  logic [ADDR_W-1:0]     i_address_upper,
    input  logic [ADDR_W-1:0]     i_address_lower,
    input  logic [SCOPE_W-1:0]    i_scope_ident,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SLOT_IDX_W-1:0] o_slot_index,
    output logic                  o_was_hit,
    output logic                  o_did_evict
);

    logic                    r_in_valid;
    t_key                    r_in_key;
    logic                    r_out_valid;
    logic [SLOT_IDX_W-1:0]   r_out_slot;
    logic                    r_out_hit;
    logic                    r_out_evict;

    logic [CACHE_ENTRIES-1:0] r_valid;
    t_key                     r_key  [CACHE_ENTRIES];
    t_slot                    r_rank [CACHE_ENTRIES];
    t_count                   r_count;

    logic [CACHE_ENTRIES-1:0] match;
    logic                     hit;
    logic                     full;
    logic                     evict;
    t_slot                    hit_slot;
    t_slot                    free_slot;
    t_slot                    victim_slot;
    t_slot                    slot;
    t_slot                    hit_rank;
    logic                     out_free;
    logic                     proc;
    logic                     in_take;

    logic [CACHE_ENTRIES-1:0] n_valid;
    t_slot                    n_rank [CACHE_ENTRIES];
    t_count                   n_count;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        hit_slot    = '0;
        free_slot   = '0;
        victim_slot = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            match[i] = r_valid[i] && (r_key[i] == r_in_key);
            if (match[i]) begin
                hit_slot = SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                free_slot = SLOT_W'(i);
            end
            if (r_rank[i] == SLOT_W'(CACHE_ENTRIES - 1)) begin
                victim_slot = SLOT_W'(i);
            end
        end
        hit      = |match;
        full     = (r_count == COUNT_W'(CACHE_ENTRIES));
        evict    = !hit && full;
        hit_rank = r_rank[hit_slot];
        if (hit) begin
            slot = hit_slot;
        end else if (full) begin
            slot = victim_slot;
        end else begin
            slot = free_slot;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (SLOT_W'(i) == slot) begin
                n_rank[i] = '0;
            end else if (r_valid[i] && (!hit || (r_rank[i] < hit_rank))) begin
                n_rank[i] = r_rank[i] + SLOT_W'(1);
            end
        end
        if (!hit) begin
            n_valid[slot] = 1'b1;
            if (!full) begin
                n_count = r_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_count     <= '0;
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (proc) begin
                r_valid <= n_valid;
                r_count <= n_count;
                for (int i = 0; i < CACHE_ENTRIES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_key.family     <= i_addr_family;
            r_in_key.port       <= i_port_number;
            r_in_key.flow       <= i_flow_label;
            r_in_key.addr_upper <= i_address_upper;
            r_in_key.addr_lower <= i_address_lower;
            r_in_key.scope      <= i_scope_ident;
        end
        if (proc) begin
            r_out_slot  <= SLOT_IDX_W'(slot);
            r_out_hit   <= hit;
            r_out_evict <= evict;
            if (!hit) begin
                r_key[slot] <= r_in_key;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_slot_index = r_out_slot;
    assign o_was_hit    = r_out_hit;
    assign o_did_evict  = r_out_evict;

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == COUNT_W'($countones(r_valid)))
        else $error("entry count differs from number of valid slots");

    a_evict_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && evict |-> &r_valid)
        else $error("eviction while a free slot exists");

    a_slot_most_recent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> (r_rank[$past(slot)] == '0) && r_valid[$past(slot)])
        else $error("looked-up slot not valid and most recent");

    a_hit_never_evicts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_was_hit |-> !o_did_evict)
        else $error("result flags both hit and eviction");

endmodule

>>> sim/tb_address_keyed_lru_cache.sv
// testbench: directed and random lookups against a predictor of the address keyed lru cache
`timescale 1ns / 1ps

module tb_address_keyed_lru_cache;
    import alkc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int POOL_SIZE   = 32;
    localparam int PHASE_ITEMS = 313;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot;
        logic                  hit;
        logic                  evict;
    } t_lookup;

    typedef struct {
        logic    chk;
        t_key    key;
        t_lookup exp;
    } t_dir_row;

    typedef struct {
        logic    is_pause;
        logic    chk;
        t_key    key;
        t_lookup exp;
        int      phase;
    } t_stim;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_in_valid      = 1'b0;
    logic [FAMILY_W-1:0]   i_addr_family   = '0;
    logic [PORT_W-1:0]     i_port_number   = '0;
    logic [FLOW_W-1:0]     i_flow_label    = '0;
    logic [ADDR_W-1:0]     i_address_upper = '0;
    logic [ADDR_W-1:0]     i_address_lower = '0;
    logic [SCOPE_W-1:0]    i_scope_ident   = '0;
    logic                  i_out_stall     = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [SLOT_IDX_W-1:0] o_slot_index;
    logic                  o_was_hit;
    logic                  o_did_evict;

    // predictor state
    logic cache_valid [CACHE_ENTRIES];
    t_key cache_key   [CACHE_ENTRIES];
    int   cache_rank  [CACHE_ENTRIES];
    int   cache_count;

    t_stim   stim_list[$];
    t_lookup lookups_pending[$];
    t_stim   cur_item;
    int      stim_idx     = 0;
    int      cur_phase    = 0;
    int      error_count  = 0;
    int      cycle_count  = 0;
    int      result_count = 0;
    int      hit_count    = 0;
    int      evict_count  = 0;
    int      idle_pct [4] = '{0, 54, 0, 31};
    int      stall_pct[4] = '{0, 0, 54, 31};

    t_dir_row directed_rows[24] = '{
        '{1'b1, '{16'h0000, 16'h0000, 32'h0, 64'h0, 64'h0, 32'h0}, '{4'd0, 1'b0, 1'b0}},
        '{1'b1, '{'1, '1, '1, '1, '1, '1}, '{4'd1, 1'b0, 1'b0}},
        '{1'b1, '{16'h0000, 16'h0000, 32'h0, 64'h0, 64'h0, 32'h0}, '{4'd0, 1'b1, 1'b0}},
        '{1'b1, '{16'hffff, 16'h0000, 32'h0, 64'h0, 64'h0, 32'h0}, '{4'd2, 1'b0, 1'b0}},
        '{1'b1, '{16'h0000, 16'hffff, 32'h0, 64'h0, 64'h0, 32'h0}, '{4'd3, 1'b0, 1'b0}},
        '{1'b1, '{16'h0000, 16'h0000, '1, 64'h0, 64'h0, 32'h0}, '{4'd4, 1'b0, 1'b0}},
        '{1'b1, '{16'h0000, 16'h0000, 32'h0, '1, 64'h0, 32'h0}, '{4'd5, 1'b0, 1'b0}},
        '{1'b1, '{16'h0000, 16'h0000, 32'h0, 64'h0, '1, 32'h0}, '{4'd6, 1'b0, 1'b0}},
        '{1'b1, '{16'h0000, 16'h0000, 32'h0, 64'h0, 64'h0, '1}, '{4'd7, 1'b0, 1'b0}},
        '{1'b1, '{16'h000a, 16'h0050, 32'h0, 64'h2001_0db8_0000_0000, 64'h1, 32'h0},
            '{4'd8, 1'b0, 1'b0}},
        '{1'b1, '{16'h000a, 16'h0050, 32'h0, 64'h2001_0db8_0000_0000, 64'h2, 32'h0},
            '{4'd9, 1'b0, 1'b0}},
        '{1'b1, '{16'h000a, 16'h0050, 32'h0, 64'h2001_0db8_0000_0000, 64'h3, 32'h0},
            '{4'd10, 1'b0, 1'b0}},
        '{1'b1, '{16'h000a, 16'h0050, 32'h0, 64'h2001_0db8_0000_0000, 64'h4, 32'h0},
            '{4'd11, 1'b0, 1'b0}},
        '{1'b1, '{16'h000a, 16'h0050, 32'h0, 64'h2001_0db8_0000_0000, 64'h5, 32'h0},
            '{4'd12, 1'b0, 1'b0}},
        '{1'b1, '{16'h000a, 16'h0050, 32'h0, 64'h2001_0db8_0000_0000, 64'h6, 32'h0},
            '{4'd13, 1'b0, 1'b0}},
        '{1'b1, '{16'h000a, 16'h0050, 32'h0, 64'h2001_0db8_0000_0000, 64'h7, 32'h0},
            '{4'd14, 1'b0, 1'b0}},
        '{1'b1, '{16'h000a, 16'h0050, 32'h0, 64'h2001_0db8_0000_0000, 64'h8, 32'h0},
            '{4'd15, 1'b0, 1'b0}},
        '{1'b1, '{16'h000a, 16'h01bb, 32'h000f_ffff, 64'hfe80_0000_0000_0000, 64'h1, 32'h2},
            '{4'd1, 1'b0, 1'b1}},
        '{1'b1, '{'1, '1, '1, '1, '1, '1}, '{4'd0, 1'b0, 1'b1}},
        '{1'b1, '{16'hffff, 16'h0000, 32'h0, 64'h0, 64'h0, 32'h0}, '{4'd2, 1'b1, 1'b0}},
        '{1'b1, '{16'h000a, 16'h0050, 32'h0, 64'h2001_0db8_0000_0000, 64'h9, 32'h0},
            '{4'd3, 1'b0, 1'b1}},
        '{1'b1, '{16'h000a, 16'h0050, 32'h0, 64'h2001_0db8_0000_0000, 64'h9, 32'h0},
            '{4'd3, 1'b1, 1'b0}},
        '{1'b0, '{16'h000a, 16'h0050, 32'h0, 64'h2001_0db8_0000_0000, 64'h9, 32'h1},
            '{4'd0, 1'b0, 1'b0}},
        '{1'b0, '{16'h0000, 16'h0000, 32'h0, 64'h0, 64'h0, 32'h0}, '{4'd0, 1'b0, 1'b0}}
    };

    address_keyed_lru_cache DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_addr_family   (i_addr_family),
        .i_port_number   (i_port_number),
        .i_flow_label    (i_flow_label),
        .i_address_upper (i_address_upper),
        .i_address_lower (i_address_lower),
        .i_scope_ident   (i_scope_ident),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_slot_index    (o_slot_index),
        .o_was_hit       (o_was_hit),
        .o_did_evict     (o_did_evict)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic t_key rand_key();
        t_key k;
        k.family     = 16'($urandom);
        k.port       = 16'($urandom);
        k.flow       = $urandom;
        k.addr_upper = {$urandom, $urandom};
        k.addr_lower = {$urandom, $urandom};
        k.scope      = $urandom;
        return k;
    endfunction

    // exact match, move to front, fill lowest free slot or replace the oldest entry
    function automatic t_lookup predict_lookup(input t_key k);
        t_lookup r;
        int      hit_slot;
        int      free_slot;
        int      slot;
        int      limit;
        int      worst;
        r         = '0;
        hit_slot  = -1;
        free_slot = -1;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (hit_slot < 0 && cache_valid[i] && cache_key[i] == k) hit_slot = i;
        end
        if (hit_slot >= 0) begin
            slot  = hit_slot;
            limit = cache_rank[slot];
            r.hit = 1'b1;
        end else begin
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                if (free_slot < 0 && !cache_valid[i]) free_slot = i;
            end
            limit = CACHE_ENTRIES + 1;
            if (free_slot >= 0) begin
                slot = free_slot;
                cache_valid[slot] = 1'b1;
                cache_count++;
            end else begin
                worst = 0;
                slot  = 0;
                for (int i = 0; i < CACHE_ENTRIES; i++) begin
                    if (cache_rank[i] > worst) begin
                        worst = cache_rank[i];
                        slot  = i;
                    end
                end
                r.evict = 1'b1;
            end
            cache_key[slot] = k;
        end
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (i != slot && cache_valid[i] && cache_rank[i] < limit) cache_rank[i]++;
        end
        cache_rank[slot] = 0;
        r.slot = SLOT_IDX_W'(slot);
        return r;
    endfunction

    always @(posedge i_clk) begin : drive_and_check
        t_lookup got;
        t_lookup want;
        t_lookup pred;
        t_stim   s;
        logic    send;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_slot_index, o_was_hit, o_did_evict};
                result_count++;
                if (got.hit === 1'b1) hit_count++;
                if (got.evict === 1'b1) evict_count++;
                if (lookups_pending.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no lookup pending", result_count));
                end else begin
                    want = lookups_pending.pop_front();
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("result %0d slot_index got %0d expected %0d",
                            result_count, got.slot, want.slot));
                    if (got.hit !== want.hit)
                        report_mismatch($sformatf("result %0d was_hit got %b expected %b",
                            result_count, got.hit, want.hit));
                    if (got.evict !== want.evict)
                        report_mismatch($sformatf("result %0d did_evict got %b expected %b",
                            result_count, got.evict, want.evict));
                end
            end

            if (i_in_valid && !o_in_stall) begin
                pred = predict_lookup(cur_item.key);
                lookups_pending.push_back(cur_item.chk ? cur_item.exp : pred);
            end

            if (!i_in_valid || !o_in_stall) begin
                send = 1'b0;
                if (stim_idx < stim_list.size()) begin
                    s = stim_list[stim_idx];
                    cur_phase = s.phase;
                    if (s.is_pause) begin
                        // hold off until every pending result is back
                        if (lookups_pending.size() == 0) stim_idx++;
                    end else if ($urandom_range(0, 99) >= idle_pct[s.phase]) begin
                        send     = 1'b1;
                        cur_item = s;
                        stim_idx++;
                        i_addr_family   <= s.key.family;
                        i_port_number   <= s.key.port;
                        i_flow_label    <= s.key.flow;
                        i_address_upper <= s.key.addr_upper;
                        i_address_lower <= s.key.addr_lower;
                        i_scope_ident   <= s.key.scope;
                    end
                end
                i_in_valid <= send;
            end
            i_out_stall <= ($urandom_range(0, 99) < stall_pct[cur_phase]);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results pending", cycle_count,
            lookups_pending.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin : main_seq
        t_stim s;
        t_key  key_pool[POOL_SIZE];
        int    pool_span[4];
        int    r;
        pool_span = '{12, 20, 16, 32};
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            cache_valid[i] = 1'b0;
            cache_key[i]   = '0;
            cache_rank[i]  = 0;
        end
        cache_count = 0;

        foreach (directed_rows[i]) begin
            s = '{1'b0, directed_rows[i].chk, directed_rows[i].key, directed_rows[i].exp, 0};
            stim_list.push_back(s);
        end
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand_key();
        for (int p = 0; p < 4; p++) begin
            s = '{1'b1, 1'b0, '0, '0, p};
            stim_list.push_back(s);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                s = '{1'b0, 1'b0, '0, '0, p};
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    s.key = key_pool[$urandom_range(0, pool_span[p] - 1)];
                end else if (r < 75) begin
                    // one bit away from a key in the pool
                    s.key = key_pool[$urandom_range(0, pool_span[p] - 1)]
                        ^ (t_key'(1) << $urandom_range(0, $bits(t_key) - 1));
                end else if (r < 90) begin
                    s.key = rand_key();
                    key_pool[$urandom_range(0, POOL_SIZE - 1)] = s.key;
                end else begin
                    s.key = rand_key();
                end
                stim_list.push_back(s);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_idx < stim_list.size() || i_in_valid || lookups_pending.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("lookups checked: %0d results, %0d hits, %0d evictions, %0d errors",
            result_count, hit_count, evict_count, error_count);
        $display("four idle and stall phases run, with drains between them; %0d slots filled",
            cache_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
